[rtl/tcg_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcg_pkg
// Shared types and constants for the text console glyph renderer.
// ----------------------------------------------------------------------------
package tcg_pkg;

  // input operations
  localparam logic [1:0] OP_PUT    = 2'd0;
  localparam logic [1:0] OP_LOAD   = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;
  localparam logic [1:0] OP_CURSOR = 2'd3;

  // result kinds
  localparam logic [1:0] KIND_GLYPH  = 2'd0;
  localparam logic [1:0] KIND_SCROLL = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;

  // commands passed from front to back
  localparam logic [1:0] CMD_GLYPH  = 2'd0;
  localparam logic [1:0] CMD_LOAD   = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;
  localparam logic [1:0] CMD_SCROLL = 2'd3;

  // control codes
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_BS  = 8'h08;

  // configuration register indexes and reset values
  localparam logic REG_COLUMNS = 1'b0;
  localparam logic REG_ROWS    = 1'b1;
  localparam logic [7:0] COLS_RESET = 8'd80;
  localparam logic [6:0] ROWS_RESET = 7'd25;

  // cell is 8 pixels wide
  localparam int CELL_SHIFT = 3;

  // font index width covering every legal glyph height and font size
  localparam int IDX_W = 13;

  localparam int PIX_W = 11;

  typedef struct packed {
    logic [1:0]       cmd;
    logic             scroll;  // glyph is followed by a scroll
    logic [IDX_W-1:0] idx;     // font index (glyph base or load address)
    logic [7:0]       data;    // font byte for loads
    logic [PIX_W-1:0] px;
    logic [PIX_W-1:0] py;
    logic [31:0]      fg;
    logic [31:0]      bg;
  } tcg_entry_t;

endpackage

[rtl/text_console_glyph_renderer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_glyph_renderer
// Text console engine: cursor, background color and font RAM, producing
// glyph row, scroll and clear results for a framebuffer writer.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_*, valid/ready) takes put-character, font-load, clear
//   and set-cursor beats. The front section updates the cursor in the cycle a
//   beat is taken and queues at most one command; a 4-entry queue decouples
//   it from the back section, which owns the font RAM.
//   Result channel (out_*, valid/ready) carries glyph rows, scroll and clear
//   results; out_last marks the final result of one input beat.
//   Back work: a printable character is dispatched, its index checked, then
//   its GLYPH_HEIGHT rows are read at one font RAM read per cycle while the
//   output accepts, plus a scroll result if it scrolls; a glyph index past
//   the font end is first wrapped by the font size. Clear and scroll-only
//   control codes yield one result, font loads one font write; set cursor
//   and non-scrolling control codes leave no back work. When the back is
//   idle, out_valid follows queue, dispatch, index check and RAM read.
//   Reset: cursor at home, background zero, 80 x 25 cells; the font RAM is
//   not cleared and must be loaded before characters are drawn.
//   When the receiver stalls, results hold in the output register, the back
//   section waits, and in_ready drops once the queue is full.
//   cfg_we writes text_columns (index 0) or text_rows (index 1) at once.
// ----------------------------------------------------------------------------
module text_console_glyph_renderer #(
  parameter int GLYPH_HEIGHT = 16,
  parameter int FONT_ENTRIES = 4096,
  parameter int QUEUE_DEPTH  = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_operation,
  input  logic [7:0]  in_char_code,
  input  logic [31:0] in_color,
  input  logic [11:0] in_font_address,
  input  logic [7:0]  in_font_data,
  input  logic [7:0]  in_cursor_column,
  input  logic [6:0]  in_cursor_row,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [10:0] out_pixel_x,
  output logic [10:0] out_pixel_y,
  output logic [7:0]  out_row_bits,
  output logic [31:0] out_foreground,
  output logic [31:0] out_background,
  output logic        out_last
);

  import tcg_pkg::*;

  tcg_entry_t push_entry;
  tcg_entry_t pop_entry;
  logic       q_push;
  logic       q_pop;
  logic       q_full;
  logic       q_empty;

  tcg_front #(
    .GLYPH_HEIGHT (GLYPH_HEIGHT),
    .FONT_ENTRIES (FONT_ENTRIES)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_char_code     (in_char_code),
    .in_color         (in_color),
    .in_font_address  (in_font_address),
    .in_font_data     (in_font_data),
    .in_cursor_column (in_cursor_column),
    .in_cursor_row    (in_cursor_row),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_entry          (push_entry)
  );

  tcg_fifo #(
    .WIDTH ($bits(tcg_entry_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (push_entry),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (pop_entry),
    .empty (q_empty)
  );

  tcg_back #(
    .GLYPH_HEIGHT (GLYPH_HEIGHT),
    .FONT_ENTRIES (FONT_ENTRIES)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_entry        (pop_entry),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind       (out_kind),
    .out_pixel_x    (out_pixel_x),
    .out_pixel_y    (out_pixel_y),
    .out_row_bits   (out_row_bits),
    .out_foreground (out_foreground),
    .out_background (out_background),
    .out_last       (out_last)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("command pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("command popped from an empty queue");

  a_fill_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind != KIND_GLYPH) |->
      out_last && (out_row_bits == 8'd0) && (out_pixel_x == 11'd0) &&
      (out_pixel_y == 11'd0) && (out_foreground == 32'd0))
    else $error("scroll or clear result with glyph fields or not last");

endmodule

[rtl/tcg_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcg_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tcg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/tcg_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcg_fifo
// Short command queue between the front and back sections.
// ----------------------------------------------------------------------------
module tcg_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int PW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW:0] rd_ptr_r, rd_ptr_nxt;

  assign empty = (wr_ptr_r == rd_ptr_r);
  assign full  = (wr_ptr_r[PW-1:0] == rd_ptr_r[PW-1:0]) && (wr_ptr_r[PW] != rd_ptr_r[PW]);
  assign dout  = mem[rd_ptr_r[PW-1:0]];

  assign wr_ptr_nxt = wr_ptr_r + (PW+1)'(push);
  assign rd_ptr_nxt = rd_ptr_r + (PW+1)'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r[PW-1:0]] <= din;
    end
  end

endmodule

[rtl/tcg_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcg_front
// Accepts input beats, keeps cursor, background and screen size, and turns
// each beat into at most one command for the back section.
// ----------------------------------------------------------------------------
module tcg_front #(
  parameter int GLYPH_HEIGHT = 16,
  parameter int FONT_ENTRIES = 4096
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [7:0]          cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_operation,
  input  logic [7:0]          in_char_code,
  input  logic [31:0]         in_color,
  input  logic [11:0]         in_font_address,
  input  logic [7:0]          in_font_data,
  input  logic [7:0]          in_cursor_column,
  input  logic [6:0]          in_cursor_row,
  input  logic                q_full,
  output logic                q_push,
  output tcg_pkg::tcg_entry_t q_entry
);

  import tcg_pkg::*;

  localparam logic [13:0] FE_C = 14'(FONT_ENTRIES);

  logic [7:0]  cols_r;
  logic [6:0]  rows_r;
  logic [7:0]  col_r, col_nxt;
  logic [6:0]  row_r, row_nxt;
  logic [31:0] bg_r, bg_nxt;

  logic [7:0] cols_eff;
  logic [6:0] rows_eff;
  logic [8:0] x_mv;
  logic [7:0] y_mv;
  logic [7:0] y_wr;
  logic [7:0] x_fin;
  logic [6:0] y_fin;
  logic       printable;
  logic       scroll;
  logic       accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  assign cols_eff = (cols_r == 8'd0) ? 8'd1 : cols_r;
  assign rows_eff = (rows_r == 7'd0) ? 7'd1 : rows_r;

  // cursor motion for a put-character beat
  always_comb begin
    x_mv      = {1'b0, col_r};
    y_mv      = {1'b0, row_r};
    printable = 1'b0;
    unique case (in_char_code)
      CH_LF: begin
        x_mv = 9'd0;
        y_mv = {1'b0, row_r} + 8'd1;
      end
      CH_CR: begin
        x_mv = 9'd0;
      end
      CH_TAB: begin
        x_mv = ({1'b0, col_r} + 9'd4) & 9'h1FC;
      end
      CH_BS: begin
        if (col_r != 8'd0) begin
          x_mv = {1'b0, col_r} - 9'd1;
        end
      end
      default: begin
        x_mv      = {1'b0, col_r} + 9'd1;
        printable = 1'b1;
      end
    endcase

    if (x_mv >= {1'b0, cols_eff}) begin
      x_fin = 8'd0;
      y_wr  = y_mv + 8'd1;
    end else begin
      x_fin = x_mv[7:0];
      y_wr  = y_mv;
    end

    scroll = (y_wr >= {1'b0, rows_eff});
    y_fin  = scroll ? (rows_eff - 7'd1) : y_wr[6:0];
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    bg_nxt  = bg_r;
    q_push  = 1'b0;

    q_entry        = '0;
    q_entry.scroll = scroll;
    q_entry.px     = PIX_W'({col_r, {CELL_SHIFT{1'b0}}});
    q_entry.py     = PIX_W'(row_r * GLYPH_HEIGHT);
    q_entry.fg     = in_color;
    q_entry.bg     = bg_r;
    q_entry.data   = in_font_data;

    unique case (in_operation)
      OP_PUT: begin
        q_entry.cmd = printable ? CMD_GLYPH : CMD_SCROLL;
        q_entry.idx = IDX_W'(in_char_code * GLYPH_HEIGHT);
        q_push      = accept && (printable || scroll);
        if (accept) begin
          col_nxt = x_fin;
          row_nxt = y_fin;
        end
      end
      OP_LOAD: begin
        q_entry.cmd = CMD_LOAD;
        q_entry.idx = IDX_W'(in_font_address);
        // loads past the end of the font are dropped
        q_push      = accept && ({2'b00, in_font_address} < FE_C);
      end
      OP_CLEAR: begin
        q_entry.cmd = CMD_CLEAR;
        q_entry.bg  = in_color;
        q_push      = accept;
        if (accept) begin
          bg_nxt  = in_color;
          col_nxt = 8'd0;
          row_nxt = 7'd0;
        end
      end
      OP_CURSOR: begin
        q_entry.cmd = CMD_SCROLL;
        if (accept) begin
          if (in_cursor_column < cols_eff) begin
            col_nxt = in_cursor_column;
          end
          if (in_cursor_row < rows_eff) begin
            row_nxt = in_cursor_row;
          end
        end
      end
      default: begin
        q_entry.cmd = CMD_SCROLL;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= COLS_RESET;
      rows_r <= ROWS_RESET;
      col_r  <= 8'd0;
      row_r  <= 7'd0;
      bg_r   <= 32'd0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      bg_r  <= bg_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_COLUMNS: cols_r <= cfg_wdata;
          REG_ROWS:    rows_r <= cfg_wdata[6:0];
          default:     cols_r <= cols_r;
        endcase
      end
    end
  end

endmodule

[rtl/tcg_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcg_back
// Executes queued commands: font writes, glyph row reads (one per cycle when
// not stalled), scroll and clear results, via read stage and output register.
// ----------------------------------------------------------------------------
module tcg_back #(
  parameter int GLYPH_HEIGHT = 16,
  parameter int FONT_ENTRIES = 4096
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  tcg_pkg::tcg_entry_t q_entry,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          out_kind,
  output logic [10:0]         out_pixel_x,
  output logic [10:0]         out_pixel_y,
  output logic [7:0]          out_row_bits,
  output logic [31:0]         out_foreground,
  output logic [31:0]         out_background,
  output logic                out_last
);

  import tcg_pkg::*;

  localparam int AW = $clog2(FONT_ENTRIES);
  localparam int RW = $clog2(GLYPH_HEIGHT);
  localparam logic [IDX_W:0] FE_C     = (IDX_W+1)'(FONT_ENTRIES);
  localparam logic [RW-1:0]  ROW_LAST = RW'(GLYPH_HEIGHT - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RED  = 2'd1;  // bring glyph base into font range
  localparam logic [1:0] ST_RUN  = 2'd2;
  localparam logic [1:0] ST_SCRL = 2'd3;

  logic [1:0] state_r, state_nxt;

  // glyph work registers
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [RW-1:0]    row_r, row_nxt;
  logic [PIX_W-1:0] px_r, px_nxt;
  logic [PIX_W-1:0] py_r, py_nxt;
  logic [31:0]      fg_r, fg_nxt;
  logic [31:0]      bg_r, bg_nxt;
  logic             scroll_r, scroll_nxt;

  // read stage
  logic             s1_v_r, s1_v_nxt;
  logic [1:0]       s1_kind_r, s1_kind_nxt;
  logic [PIX_W-1:0] s1_px_r, s1_px_nxt;
  logic [PIX_W-1:0] s1_py_r, s1_py_nxt;
  logic [31:0]      s1_fg_r, s1_fg_nxt;
  logic [31:0]      s1_bg_r, s1_bg_nxt;
  logic             s1_last_r, s1_last_nxt;

  // output register
  logic             out_valid_r;
  logic [1:0]       out_kind_r;
  logic [PIX_W-1:0] out_px_r;
  logic [PIX_W-1:0] out_py_r;
  logic [7:0]       out_bits_r;
  logic [31:0]      out_fg_r;
  logic [31:0]      out_bg_r;
  logic             out_last_r;

  logic             ram_we;
  logic             ram_re;
  logic [7:0]       ram_rdata;
  logic             out_load;
  logic             s1_free;
  logic             s1_set;
  logic [IDX_W:0]   idx_inc;

  tcg_ram #(
    .WIDTH (8),
    .DEPTH (FONT_ENTRIES)
  ) u_font (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(q_entry.idx)),
    .wdata (q_entry.data),
    .re    (ram_re),
    .raddr (AW'(idx_r)),
    .rdata (ram_rdata)
  );

  assign out_load = s1_v_r && (!out_valid_r || out_ready);
  assign s1_free  = !s1_v_r || out_load;
  assign idx_inc  = {1'b0, idx_r} + (IDX_W+1)'(1);

  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    row_nxt     = row_r;
    px_nxt      = px_r;
    py_nxt      = py_r;
    fg_nxt      = fg_r;
    bg_nxt      = bg_r;
    scroll_nxt  = scroll_r;
    q_pop       = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    s1_set      = 1'b0;
    s1_kind_nxt = s1_kind_r;
    s1_px_nxt   = s1_px_r;
    s1_py_nxt   = s1_py_r;
    s1_fg_nxt   = s1_fg_r;
    s1_bg_nxt   = s1_bg_r;
    s1_last_nxt = s1_last_r;

    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          unique case (q_entry.cmd)
            CMD_LOAD: begin
              ram_we = 1'b1;
              q_pop  = 1'b1;
            end
            CMD_CLEAR, CMD_SCROLL: begin
              if (s1_free) begin
                s1_set      = 1'b1;
                s1_kind_nxt = (q_entry.cmd == CMD_CLEAR) ? KIND_CLEAR : KIND_SCROLL;
                s1_px_nxt   = '0;
                s1_py_nxt   = '0;
                s1_fg_nxt   = '0;
                s1_bg_nxt   = q_entry.bg;
                s1_last_nxt = 1'b1;
                q_pop       = 1'b1;
              end
            end
            CMD_GLYPH: begin
              idx_nxt    = q_entry.idx;
              row_nxt    = '0;
              px_nxt     = q_entry.px;
              py_nxt     = q_entry.py;
              fg_nxt     = q_entry.fg;
              bg_nxt     = q_entry.bg;
              scroll_nxt = q_entry.scroll;
              q_pop      = 1'b1;
              state_nxt  = ST_RED;
            end
            default: begin
              q_pop = 1'b0;
            end
          endcase
        end
      end
      ST_RED: begin
        // glyph index wraps modulo the font size
        if ({1'b0, idx_r} >= FE_C) begin
          idx_nxt = IDX_W'({1'b0, idx_r} - FE_C);
        end else begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (s1_free) begin
          ram_re      = 1'b1;
          s1_set      = 1'b1;
          s1_kind_nxt = KIND_GLYPH;
          s1_px_nxt   = px_r;
          s1_py_nxt   = py_r + PIX_W'(row_r);
          s1_fg_nxt   = fg_r;
          s1_bg_nxt   = bg_r;
          s1_last_nxt = (row_r == ROW_LAST) && !scroll_r;
          row_nxt     = row_r + RW'(1);
          idx_nxt     = (idx_inc == FE_C) ? '0 : IDX_W'(idx_inc);
          if (row_r == ROW_LAST) begin
            state_nxt = scroll_r ? ST_SCRL : ST_IDLE;
          end
        end
      end
      ST_SCRL: begin
        if (s1_free) begin
          s1_set      = 1'b1;
          s1_kind_nxt = KIND_SCROLL;
          s1_px_nxt   = '0;
          s1_py_nxt   = '0;
          s1_fg_nxt   = '0;
          s1_bg_nxt   = bg_r;
          s1_last_nxt = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (s1_set) begin
      s1_v_nxt = 1'b1;
    end else if (out_load) begin
      s1_v_nxt = 1'b0;
    end else begin
      s1_v_nxt = s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      s1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      s1_v_r  <= s1_v_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    row_r     <= row_nxt;
    px_r      <= px_nxt;
    py_r      <= py_nxt;
    fg_r      <= fg_nxt;
    bg_r      <= bg_nxt;
    scroll_r  <= scroll_nxt;
    s1_kind_r <= s1_kind_nxt;
    s1_px_r   <= s1_px_nxt;
    s1_py_r   <= s1_py_nxt;
    s1_fg_r   <= s1_fg_nxt;
    s1_bg_r   <= s1_bg_nxt;
    s1_last_r <= s1_last_nxt;
    if (out_load) begin
      out_kind_r <= s1_kind_r;
      out_px_r   <= s1_px_r;
      out_py_r   <= s1_py_r;
      // font byte comes from the RAM's registered read data, in the cycle after the read
      out_bits_r <= (s1_kind_r == KIND_GLYPH) ? ram_rdata : 8'd0;
      out_fg_r   <= s1_fg_r;
      out_bg_r   <= s1_bg_r;
      out_last_r <= s1_last_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_pixel_x    = out_px_r;
  assign out_pixel_y    = out_py_r;
  assign out_row_bits   = out_bits_r;
  assign out_foreground = out_fg_r;
  assign out_background = out_bg_r;
  assign out_last       = out_last_r;

endmodule
